// ===== hw/rtl/midi_pad_event_collector_top_macros.svh =====
// Assertion macros for the pad event collector. They assume a clock named clk and an
// active-low reset named rst_n in the scope where they are used.
`ifndef MIDI_PAD_EVENT_COLLECTOR_TOP_MACROS_SVH
`define MIDI_PAD_EVENT_COLLECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define MPEC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("mpec assertion failed");
// The expression must never be true outside reset.
`define MPEC_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("mpec forbidden condition seen");
`else
`define MPEC_ASSERT(label, prop)
`define MPEC_ASSERT_NEVER(label, expr)
`endif

`endif

// ===== hw/rtl/mpec_pkg.sv =====
package mpec_pkg;

    // Default sizes.
    localparam int LIST_DEPTH_DEF  = 16;
    localparam int FADER_COUNT_DEF = 9;

    // Status byte decoding.
    localparam logic [7:0] STATUS_MASK     = 8'hF0;
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;
    localparam logic [7:0] STATUS_CTRL_CHG = 8'hB0;

    // The first fader sits at this controller number.
    localparam logic [7:0] FADER_BASE = 8'd48;

    // Result kinds.
    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_CTRL_CHG = 2'd2;

    // A search probe as it moves from one list cell to the next.
    typedef struct packed {
        logic       valid;
        logic       hit;
        logic [7:0] note;
    } mpec_probe_t;

endpackage

// ===== hw/rtl/mpec_cell.sv =====
module mpec_cell
    import mpec_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CNT_W-1:0]  count,
    input  mpec_probe_t       probe_in,
    output mpec_probe_t       probe_out,
    input  logic              wr_en,
    input  logic [7:0]        wr_note
);

    logic [7:0]  entry_reg;
    mpec_probe_t probe_reg;
    mpec_probe_t probe_next;
    logic        live;

    // Only entries below the fill count take part in the search.
    assign live = CNT_W'(INDEX) < count;

    always_comb
    begin
        probe_next     = probe_in;
        probe_next.hit = probe_in.hit
                       | (probe_in.valid & live & (entry_reg == probe_in.note));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    // The entry is written each time the list grows into this position.
    always_ff @(posedge clk)
    begin
        if (wr_en && (count == CNT_W'(INDEX)))
        begin
            entry_reg <= wr_note;
        end
    end

    assign probe_out = probe_reg;

endmodule

// ===== hw/rtl/mpec_list.sv =====
module mpec_list
    import mpec_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF,
    parameter int CNT_W      = $clog2(LIST_DEPTH + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clear,
    input  logic              start,
    input  logic [7:0]        note,
    output logic              done,
    output logic              added,
    output logic [CNT_W-1:0]  count
);

    mpec_probe_t        chain [LIST_DEPTH+1];
    mpec_probe_t        tail;
    logic               append;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               done_reg;
    logic               added_reg;

    assign chain[0] = '{valid: start, hit: 1'b0, note: note};

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            mpec_cell #(
                .INDEX (gi),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .count     (count_reg),
                .probe_in  (chain[gi]),
                .probe_out (chain[gi+1]),
                .wr_en     (append),
                .wr_note   (tail.note)
            );
        end
    endgenerate

    assign tail = chain[LIST_DEPTH];

    // A probe that left the last cell without a match is appended if there is room.
    assign append = tail.valid && !tail.hit && (count_reg < CNT_W'(LIST_DEPTH));

    always_comb
    begin
        count_next = count_reg;
        if (clear)
        begin
            count_next = '0;
        end
        else if (append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
            added_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= tail.valid;
            added_reg <= append;
        end
    end

    assign done  = done_reg;
    assign added = added_reg;
    assign count = count_reg;

endmodule

// ===== hw/rtl/midi_pad_event_collector_top.sv =====
// MIDI pad event collector. Each request carries either one raw MIDI byte (func low) or a
// command to empty the press and release lists (func high). A note-on, note-off or control
// change status byte starts a three-byte message; any other byte seen between messages is
// dropped, and once a message has started the next two bytes are taken as its data whatever
// their value. Every completed message yields one result: notes are added to the press or
// release list unless already present or the list is full, and control changes set one of
// FADER_COUNT fader levels counted from controller 48, or are flagged as ignored beyond them.
// The byte that finishes a note message launches a probe down a row of LIST_DEPTH list cells
// (16 by default), one cell per cycle, and the result is registered once the probe has left
// the last cell; no request is taken during that search. A finished control change lands in
// the output register in the same cycle. The output register holds one result, so bytes keep
// flowing while a result waits, but a byte that would finish a further message is held off
// until the output register has been emptied. The list entries have no reset; only entries
// below each list's count are ever compared.
`include "midi_pad_event_collector_top_macros.svh"

module midi_pad_event_collector_top
    import mpec_pkg::*;
#(
    parameter int LIST_DEPTH  = LIST_DEPTH_DEF,
    parameter int FADER_COUNT = FADER_COUNT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  msg_kind,
    output logic [7:0]  number,
    output logic [7:0]  amount,
    output logic        newly_added,
    output logic        fader_ignored,
    output logic [4:0]  pressed_total,
    output logic [4:0]  released_total
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    // Parser modes.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_OFF  = 2'd2;
    localparam logic [1:0] MODE_CC   = 2'd3;

    // Control states.
    localparam logic CTL_READY  = 1'b0;
    localparam logic CTL_SEARCH = 1'b1;

    logic [1:0]        mode_reg;
    logic [1:0]        held_reg;
    logic [7:0]        num_reg;
    logic [7:0]        amt_reg;
    logic              ctl_reg;
    logic              ctl_next;

    logic              out_valid_reg;
    logic [1:0]        kind_reg;
    logic [7:0]        out_num_reg;
    logic [7:0]        out_amt_reg;
    logic              added_reg;
    logic              ignored_reg;
    logic [4:0]        press_tot_reg;
    logic [4:0]        rel_tot_reg;

    logic [7:0]        fader_reg [FADER_COUNT];

    logic              in_fire;
    logic              completing;
    logic              clear;
    logic              press_start;
    logic              rel_start;
    logic              cc_done;
    logic [7:0]        slot;
    logic              slot_ok;
    logic [7:0]        status_hi;

    logic              press_done;
    logic              press_added;
    logic [CNT_W-1:0]  press_count;
    logic              rel_done;
    logic              rel_added;
    logic [CNT_W-1:0]  rel_count;

    // The current byte finishes a message when two bytes of it are already held.
    assign completing = !func && (mode_reg != MODE_IDLE) && (held_reg == 2'd2);

    // Hold off a finishing byte while the output register is still occupied.
    assign in_ready = (ctl_reg == CTL_READY) && !(out_valid_reg && completing);
    assign in_fire  = in_valid && in_ready;

    assign clear       = in_fire && func;
    assign press_start = in_fire && completing && (mode_reg == MODE_ON);
    assign rel_start   = in_fire && completing && (mode_reg == MODE_OFF);
    assign cc_done     = in_fire && completing && (mode_reg == MODE_CC);

    // Fader slot is the controller number less 48, with lower numbers folded onto slot zero.
    assign slot    = (num_reg > FADER_BASE) ? (num_reg - FADER_BASE) : 8'd0;
    assign slot_ok = slot < 8'(FADER_COUNT);

    assign status_hi = byte_value & STATUS_MASK;

    // Message parser.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            held_reg <= 2'd0;
        end
        else if (in_fire && !func)
        begin
            if (mode_reg == MODE_IDLE)
            begin
                held_reg <= 2'd1;
                case (status_hi)
                    STATUS_NOTE_ON:  mode_reg <= MODE_ON;
                    STATUS_NOTE_OFF: mode_reg <= MODE_OFF;
                    STATUS_CTRL_CHG: mode_reg <= MODE_CC;
                    default:         mode_reg <= MODE_IDLE;
                endcase
            end
            else if (held_reg == 2'd1)
            begin
                held_reg <= 2'd2;
            end
            else
            begin
                held_reg <= 2'd0;
                mode_reg <= MODE_IDLE;
            end
        end
    end

    // Data bytes of the message being parsed.
    always_ff @(posedge clk)
    begin
        if (in_fire && !func && (mode_reg != MODE_IDLE))
        begin
            if (held_reg == 2'd1)
            begin
                num_reg <= byte_value;
            end
            else
            begin
                amt_reg <= byte_value;
            end
        end
    end

    // The press and release lists, each a row of search cells.
    mpec_list #(
        .LIST_DEPTH (LIST_DEPTH),
        .CNT_W      (CNT_W)
    ) u_press (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (clear),
        .start (press_start),
        .note  (num_reg),
        .done  (press_done),
        .added (press_added),
        .count (press_count)
    );

    mpec_list #(
        .LIST_DEPTH (LIST_DEPTH),
        .CNT_W      (CNT_W)
    ) u_release (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (clear),
        .start (rel_start),
        .note  (num_reg),
        .done  (rel_done),
        .added (rel_added),
        .count (rel_count)
    );

    // While a list search runs no request is taken.
    always_comb
    begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            CTL_READY:
            begin
                if (press_start || rel_start)
                begin
                    ctl_next = CTL_SEARCH;
                end
            end
            CTL_SEARCH:
            begin
                if (press_done || rel_done)
                begin
                    ctl_next = CTL_READY;
                end
            end
            default:
            begin
                ctl_next = CTL_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= CTL_READY;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    // Fader levels.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < FADER_COUNT; i++)
            begin
                fader_reg[i] <= 8'd0;
            end
        end
        else if (cc_done)
        begin
            for (int i = 0; i < FADER_COUNT; i++)
            begin
                if (slot == 8'(i))
                begin
                    fader_reg[i] <= byte_value;
                end
            end
        end
    end

    // Output register. A control change loads it directly; a note loads it when its list
    // search has finished, by which time the list count already includes the new entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cc_done || press_done || rel_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cc_done)
        begin
            kind_reg      <= KIND_CTRL_CHG;
            out_num_reg   <= num_reg;
            out_amt_reg   <= byte_value;
            added_reg     <= 1'b0;
            ignored_reg   <= !slot_ok;
            press_tot_reg <= 5'(press_count);
            rel_tot_reg   <= 5'(rel_count);
        end
        else if (press_done || rel_done)
        begin
            kind_reg      <= press_done ? KIND_NOTE_ON : KIND_NOTE_OFF;
            out_num_reg   <= num_reg;
            out_amt_reg   <= amt_reg;
            added_reg     <= press_done ? press_added : rel_added;
            ignored_reg   <= 1'b0;
            press_tot_reg <= 5'(press_count);
            rel_tot_reg   <= 5'(rel_count);
        end
    end

    assign out_valid      = out_valid_reg;
    assign msg_kind       = kind_reg;
    assign number         = out_num_reg;
    assign amount         = out_amt_reg;
    assign newly_added    = added_reg;
    assign fader_ignored  = ignored_reg;
    assign pressed_total  = press_tot_reg;
    assign released_total = rel_tot_reg;

    // A list only reports back while a search is outstanding.
    `MPEC_ASSERT(a_done_in_search, (press_done || rel_done) |-> (ctl_reg == CTL_SEARCH))
    // Only one list is ever searched at a time.
    `MPEC_ASSERT_NEVER(a_one_list, press_done && rel_done)
    // A note reported as added leaves its list non-empty.
    `MPEC_ASSERT(a_added_count, (press_done && press_added) |-> (press_count != '0))

endmodule
